### hdl/midi_note_state_tracker_assert.svh
// ----------------------------------------------------------------------------
// MIDI note state tracker assertion macros
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_STATE_TRACKER_ASSERT_SVH
`define MIDI_NOTE_STATE_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mnst check failed");

// The consequent must hold in the cycle after the antecedent.
`define MNST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mnst check failed");

`endif

### hdl/mnst_pkg.sv
// ----------------------------------------------------------------------------
// mnst_pkg
// Shared types, codes and constants of the MIDI note state tracker.
// ----------------------------------------------------------------------------
package mnst_pkg;

    localparam int NOTE_COUNT_DEF  = 128;
    localparam int QUEUE_DEPTH_DEF = 128;

    localparam int TIME_W = 32;
    localparam int BYTE_W = 8;

    // Upper nibble of the status byte.
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CTRL     = 4'hB;

    localparam logic [BYTE_W-1:0] SUSTAIN_CC     = 8'd64;
    localparam logic [BYTE_W-1:0] PEDAL_THRESH   = 8'h3F;
    localparam logic [BYTE_W-1:0] RELEASE_VEL    = 8'h3F;

    typedef enum logic [1:0] {
        FUNC_MSG   = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_QOUT,
        S_DRAIN_RD,
        S_DRAIN_WR
    } state_t;

    // Result of the shared adder: the sum and whether it equals the compare word.
    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              hit;
    } alu_res_t;

endpackage

### hdl/mnst_ram.sv
// ----------------------------------------------------------------------------
// mnst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mnst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mnst_alu.sv
// ----------------------------------------------------------------------------
// mnst_alu
// Shared 32-bit adder with an equality compare on its sum.
// ----------------------------------------------------------------------------
module mnst_alu
    import mnst_pkg::*;
(
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    input  logic [TIME_W-1:0] cmp,
    output alu_res_t          res
);

    logic [TIME_W-1:0] sum;

    assign sum     = a + b;
    assign res.sum = sum;
    assign res.hit = (sum == cmp);

endmodule

### hdl/midi_note_state_tracker.sv
// A message or a clear is done in the execute step. A query reads the tables in
// the execute step; its result is registered once the output is free. A pedal
// release drains queued note-offs: each needs a queue read then a table write.
// One item is worked on at a time; s_tready is high only between items.
// Reset (synchronous, aresetn low) clears the note table at once through its
// per-note valid flags, empties the queue and releases the pedal.
// ----------------------------------------------------------------------------
// midi_note_state_tracker
// Tracks note-on/off state, velocities and times, with sustain pedal deferral.
// ----------------------------------------------------------------------------
module midi_note_state_tracker
    import mnst_pkg::*;
#(
    parameter int NOTE_COUNT  = NOTE_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // status_byte[7:0], data_one[15:8], data_two[23:16], event_offset[55:24],
    // now_time[87:56], query_note[95:88]
    input  logic [95:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // note_is_on[0], velocity_on[8:1], velocity_off[16:9], start_time[48:17],
    // stop_time[80:49], zero pad[87:81]
    output logic [87:0] m_tdata,
    // note_found[0]
    output logic [0:0]  m_tuser
);

    localparam int NW  = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = BYTE_W + TIME_W;

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    logic [1:0]        func_reg, func_next;
    logic [BYTE_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0] d1_reg, d1_next;
    logic [BYTE_W-1:0] d2_reg, d2_next;
    logic [TIME_W-1:0] offset_reg, offset_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [BYTE_W-1:0] q_reg, q_next;

    logic [NOTE_COUNT-1:0] on_flag_reg, on_flag_next;
    logic [NOTE_COUNT-1:0] on_valid_reg, on_valid_next;
    logic [NOTE_COUNT-1:0] off_valid_reg, off_valid_next;

    logic          pedal_reg, pedal_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic              found_reg, found_next;
    logic              is_on_reg, is_on_next;
    logic [BYTE_W-1:0] von_reg, von_next;
    logic [BYTE_W-1:0] voff_reg, voff_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] stop_reg, stop_next;

    // ---------------------------------------------------------------- decode
    logic accept;
    logic out_free;
    logic note_ok;
    logic query_ok;
    logic is_note_on;
    logic is_note_off;
    logic is_pedal;
    logic pedal_down;
    logic queue_full;

    logic [NW-1:0] d1_idx;
    logic [NW-1:0] q_idx;

    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign d1_idx     = d1_reg[NW-1:0];
    assign q_idx      = q_reg[NW-1:0];
    assign note_ok    = {1'b0, d1_reg} < 9'(NOTE_COUNT);
    assign query_ok   = {1'b0, q_reg} < 9'(NOTE_COUNT);
    assign is_note_on  = (status_reg[7:4] == MSG_NOTE_ON);
    assign is_note_off = (status_reg[7:4] == MSG_NOTE_OFF);
    assign is_pedal    = (status_reg[7:4] == MSG_CTRL) && (d1_reg == SUSTAIN_CC);
    assign pedal_down  = (d2_reg > PEDAL_THRESH);
    assign queue_full  = (count_reg == CW'(QUEUE_DEPTH));

    // ---------------------------------------------------------------- shared adder
    // Event time in the execute step, queue index step while draining.
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic [TIME_W-1:0] alu_cmp;
    alu_res_t          alu_res;

    assign alu_a   = (state_reg == S_DRAIN_WR) ? TIME_W'(idx_reg) : offset_reg;
    assign alu_b   = (state_reg == S_DRAIN_WR) ? TIME_W'(1) : now_reg;
    assign alu_cmp = TIME_W'(count_reg);

    mnst_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .cmp (alu_cmp),
        .res (alu_res)
    );

    // ---------------------------------------------------------------- memories
    logic             on_we;
    logic             off_we;
    logic [NW-1:0]    off_waddr;
    logic [ENT_W-1:0] off_wdata;
    logic             tbl_re;
    logic [ENT_W-1:0] on_rdata;
    logic [ENT_W-1:0] off_rdata;
    logic             q_we;
    logic             q_re;
    logic [NW-1:0]    q_rdata;

    mnst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NOTE_COUNT)
    ) u_on_ram (
        .aclk  (aclk),
        .we    (on_we),
        .waddr (d1_idx),
        .wdata ({d2_reg, alu_res.sum}),
        .re    (tbl_re),
        .raddr (q_idx),
        .rdata (on_rdata)
    );

    mnst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NOTE_COUNT)
    ) u_off_ram (
        .aclk  (aclk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .re    (tbl_re),
        .raddr (q_idx),
        .rdata (off_rdata)
    );

    mnst_ram #(
        .WIDTH (NW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (count_reg[QAW-1:0]),
        .wdata (d1_idx),
        .re    (q_re),
        .raddr (idx_reg[QAW-1:0]),
        .rdata (q_rdata)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (func_reg == FUNC_QUERY) begin
                    state_next = S_QOUT;
                end else if (func_reg == FUNC_MSG && is_pedal && !pedal_down
                             && count_reg != '0) begin
                    state_next = S_DRAIN_RD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_QOUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN_RD: begin
                state_next = S_DRAIN_WR;
            end
            S_DRAIN_WR: begin
                if (alu_res.hit) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_DRAIN_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        func_next      = func_reg;
        status_next    = status_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        offset_next    = offset_reg;
        now_next       = now_reg;
        q_next         = q_reg;
        on_flag_next   = on_flag_reg;
        on_valid_next  = on_valid_reg;
        off_valid_next = off_valid_reg;
        pedal_next     = pedal_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        is_on_next     = is_on_reg;
        von_next       = von_reg;
        voff_next      = voff_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        on_we          = 1'b0;
        off_we         = 1'b0;
        off_waddr      = d1_idx;
        off_wdata      = {d2_reg, alu_res.sum};
        tbl_re         = 1'b0;
        q_we           = 1'b0;
        q_re           = 1'b0;

        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    func_next   = s_tuser;
                    status_next = s_tdata[7:0];
                    d1_next     = s_tdata[15:8];
                    d2_next     = s_tdata[23:16];
                    offset_next = s_tdata[55:24];
                    now_next    = s_tdata[87:56];
                    q_next      = s_tdata[95:88];
                end
            end
            S_EXEC: begin
                case (func_reg)
                    FUNC_MSG: begin
                        if (is_note_on && note_ok) begin
                            on_we                 = 1'b1;
                            on_flag_next[d1_idx]  = 1'b1;
                            on_valid_next[d1_idx] = 1'b1;
                        end else if (is_note_off && note_ok) begin
                            if (pedal_reg) begin
                                // A full queue drops the note-off.
                                if (!queue_full) begin
                                    q_we       = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end
                            end else begin
                                off_we                 = 1'b1;
                                on_flag_next[d1_idx]   = 1'b0;
                                off_valid_next[d1_idx] = 1'b1;
                            end
                        end else if (is_pedal) begin
                            if (pedal_down) begin
                                pedal_next = 1'b1;
                            end else begin
                                pedal_next = 1'b0;
                                idx_next   = '0;
                            end
                        end
                    end
                    FUNC_QUERY: begin
                        tbl_re = 1'b1;
                    end
                    FUNC_CLEAR: begin
                        on_flag_next   = '0;
                        on_valid_next  = '0;
                        off_valid_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_QOUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    found_next    = query_ok;
                    is_on_next    = query_ok && on_flag_reg[q_idx];
                    if (query_ok && on_valid_reg[q_idx]) begin
                        von_next   = on_rdata[ENT_W-1:TIME_W];
                        start_next = on_rdata[TIME_W-1:0];
                    end else begin
                        von_next   = '0;
                        start_next = '0;
                    end
                    if (query_ok && off_valid_reg[q_idx]) begin
                        voff_next = off_rdata[ENT_W-1:TIME_W];
                        stop_next = off_rdata[TIME_W-1:0];
                    end else begin
                        voff_next = '0;
                        stop_next = '0;
                    end
                end
            end
            S_DRAIN_RD: begin
                q_re = 1'b1;
            end
            S_DRAIN_WR: begin
                // Deferred note-offs play at the release time with a fixed velocity.
                off_we                  = 1'b1;
                off_waddr               = q_rdata;
                off_wdata               = {RELEASE_VEL, now_reg};
                on_flag_next[q_rdata]   = 1'b0;
                off_valid_next[q_rdata] = 1'b1;
                idx_next                = alu_res.sum[CW-1:0];
                if (alu_res.hit) begin
                    count_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            on_flag_reg   <= '0;
            on_valid_reg  <= '0;
            off_valid_reg <= '0;
            pedal_reg     <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            on_flag_reg   <= on_flag_next;
            on_valid_reg  <= on_valid_next;
            off_valid_reg <= off_valid_next;
            pedal_reg     <= pedal_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        status_reg <= status_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        offset_reg <= offset_next;
        now_reg    <= now_next;
        q_reg      <= q_next;
        found_reg  <= found_next;
        is_on_reg  <= is_on_next;
        von_reg    <= von_next;
        voff_reg   <= voff_next;
        start_reg  <= start_next;
        stop_reg   <= stop_next;
    end

    // ---------------------------------------------------------------- ports
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = found_reg;
    assign m_tdata    = {7'd0, stop_reg, start_reg, voff_reg, von_reg, is_on_reg};

    // ---------------------------------------------------------------- checks
    `include "midi_note_state_tracker_assert.svh"

    `MNST_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `MNST_ASSERT_SAME(a_drain_pedal_up,
        state_reg == S_DRAIN_RD || state_reg == S_DRAIN_WR, !pedal_reg)
    `MNST_ASSERT_NEXT(a_result_held,
        state_reg == S_QOUT && m_tvalid_reg && !m_tready, state_reg == S_QOUT)
    `MNST_ASSERT_NEXT(a_busy_after_beat, accept, state_reg == S_EXEC)
    `MNST_ASSERT_NEXT(a_drain_empties,
        state_reg == S_DRAIN_WR && alu_res.hit, count_reg == '0 && state_reg == S_IDLE)

endmodule
